>>> sv/pdq_pkg.sv
// ----------------------------------------------------------------------------
// pdq_pkg: shared types and constants of the priority deadline queue
// entry layout, control word handed to every cell, status and operation codes
// ----------------------------------------------------------------------------
package pdq_pkg;

    // default queue depth
    localparam int DEPTH_DEF = 16;

    localparam int PRIO_W   = 2;
    localparam int DUE_W    = 32;
    localparam int TAG_W    = 16;
    localparam int STATUS_W = 2;
    localparam int OCC_W    = 5;

    // slave side word: prio, due, tag from the lowest bit up
    localparam int IN_DATA_W  = 56;
    // master side word: prio, due, tag, occupancy from the lowest bit up
    localparam int OUT_DATA_W = 56;

    // operation codes carried in tuser
    localparam logic FUNC_PUSH = 1'b0;
    localparam logic FUNC_POP  = 1'b1;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic [TAG_W-1:0]  tag;
        logic [DUE_W-1:0]  due;
        logic [PRIO_W-1:0] prio;
    } t_entry;

    // control broadcast to the row of cells
    typedef struct packed {
        logic   push;
        logic   pop;
        t_entry new_entry;
    } t_cell_ctl;

    // held entry a stays ahead of a newly pushed entry b
    function automatic logic stays_ahead(input t_entry a, input t_entry b);
        logic r;
        if (a.prio != b.prio) begin
            r = (a.prio < b.prio);
        end else begin
            r = (a.due <= b.due);
        end
        return r;
    endfunction

endpackage

>>> sv/pdq_cell.sv
// ----------------------------------------------------------------------------
// pdq_cell: one slot of the sorted queue
// compares its entry against a pushed entry, then keeps, inserts or shifts
// ----------------------------------------------------------------------------
module pdq_cell (
    input  logic               i_clk,
    input  logic               i_occupied,    // slot lies below the fill count
    input  pdq_pkg::t_cell_ctl i_ctl,
    input  logic               i_prev_ahead,  // previous slot stays in place
    input  pdq_pkg::t_entry    i_prev_entry,
    input  pdq_pkg::t_entry    i_next_entry,
    output logic               o_ahead,
    output pdq_pkg::t_entry    o_entry
);
    import pdq_pkg::*;

    t_entry r_entry;
    t_entry n_entry;

    // entry stays in place on a push
    assign o_ahead = i_occupied && stays_ahead(r_entry, i_ctl.new_entry);
    assign o_entry = r_entry;

    // next slot content
    always_comb begin
        n_entry = r_entry;
        if (i_ctl.push) begin
            if (!o_ahead) begin
                n_entry = i_prev_ahead ? i_ctl.new_entry : i_prev_entry;
            end
        end else if (i_ctl.pop) begin
            n_entry = i_next_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

endmodule

>>> sv/priority_deadline_queue.sv
// ----------------------------------------------------------------------------
// priority_deadline_queue: bounded sorted queue of tasks
// push inserts by priority class then due time (fifo among equal keys),
// pop returns the head entry; one result word per input word
// ----------------------------------------------------------------------------
// result: registered, shown in the cycle after the input word is taken
// throughput: one word per cycle, set by the single compare-and-shift pass
//   through the row of cells, while m_axis_tready is high or no result waits
// reset: synchronous active-low i_rst_n empties the queue and clears the
//   output valid; stored entries and output payload keep old, unused contents
module priority_deadline_queue #(
    parameter int DEPTH = pdq_pkg::DEPTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // prio_class[1:0], due_minutes[33:2], task_tag[49:34], zero fill
    input  logic [pdq_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // func[0]
    input  logic                           s_axis_tuser,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // out_prio[1:0], out_due[33:2], out_tag[49:34], occupancy[54:50], zero fill
    output logic [pdq_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    // status[1:0]
    output logic [pdq_pkg::STATUS_W-1:0]   m_axis_tuser
);
    import pdq_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [CNT_W-1:0]      r_count;
    logic [CNT_W-1:0]      n_count;
    logic                  r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data;
    logic [STATUS_W-1:0]   r_out_user;
    logic [OUT_DATA_W-1:0] n_out_data;
    logic [STATUS_W-1:0]   n_out_user;

    logic      w_accept;
    logic      w_full;
    logic      w_empty;
    t_entry    w_new;
    t_entry    w_head;
    t_cell_ctl w_ctl;
    logic [31:0] w_cnt32;

    logic   w_ahead [DEPTH];
    t_entry w_entry [DEPTH];

    // handshake
    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_full        = (r_count == CNT_W'(DEPTH));
    assign w_empty       = (r_count == '0);

    // unpack the input word
    assign w_new.prio = s_axis_tdata[PRIO_W-1:0];
    assign w_new.due  = s_axis_tdata[PRIO_W+DUE_W-1:PRIO_W];
    assign w_new.tag  = s_axis_tdata[PRIO_W+DUE_W+TAG_W-1:PRIO_W+DUE_W];

    assign w_ctl.push      = w_accept && (s_axis_tuser == FUNC_PUSH) && !w_full;
    assign w_ctl.pop       = w_accept && (s_axis_tuser == FUNC_POP) && !w_empty;
    assign w_ctl.new_entry = w_new;

    // row of cells, head at index zero
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        localparam logic [CNT_W-1:0] IDX = CNT_W'(g);
        logic   w_prev_ahead;
        t_entry w_prev_entry;
        t_entry w_next_entry;

        if (g == 0) begin : g_head
            assign w_prev_ahead = 1'b1;
            assign w_prev_entry = w_new;
        end else begin : g_mid
            assign w_prev_ahead = w_ahead[g-1];
            assign w_prev_entry = w_entry[g-1];
        end

        if (g == DEPTH - 1) begin : g_tail
            assign w_next_entry = w_entry[g];
        end else begin : g_body
            assign w_next_entry = w_entry[g+1];
        end

        pdq_cell u_cell (
            .i_clk        (i_clk),
            .i_occupied   (IDX < r_count),
            .i_ctl        (w_ctl),
            .i_prev_ahead (w_prev_ahead),
            .i_prev_entry (w_prev_entry),
            .i_next_entry (w_next_entry),
            .o_ahead      (w_ahead[g]),
            .o_entry      (w_entry[g])
        );
    end

    // fill count update
    always_comb begin
        n_count = r_count;
        if (w_ctl.push) begin
            n_count = r_count + CNT_W'(1);
        end else if (w_ctl.pop) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    assign w_cnt32 = 32'(n_count);

    // result word
    always_comb begin
        w_head = '0;
        if (w_ctl.pop) begin
            w_head = w_entry[0];
        end
        priority if (s_axis_tuser == FUNC_PUSH && w_full) begin
            n_out_user = ST_FULL;
        end else if (s_axis_tuser == FUNC_POP && w_empty) begin
            n_out_user = ST_EMPTY;
        end else begin
            n_out_user = ST_DONE;
        end
        n_out_data = {(OUT_DATA_W - PRIO_W - DUE_W - TAG_W - OCC_W)'(0),
                      w_cnt32[OCC_W-1:0], w_head.tag, w_head.due, w_head.prio};
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            if (w_accept) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // output payload register
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out_data <= n_out_data;
            r_out_user <= n_out_user;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_user;

endmodule

>>> verif/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: testbench of the priority deadline queue
// drives push and pop words with random idling on both sides, keeps its own
// sorted copy of the queue and checks every result word field by field
// ----------------------------------------------------------------------------
module tb;
    import pdq_pkg::*;

    localparam int QDEPTH     = DEPTH_DEF;
    localparam int QUIET_MAX  = 5000;
    localparam int PHASE_LEN  = 500;
    localparam int CHUNK_LEN  = 40;
    localparam int HOLD_LEN   = 80;

    // one result word as the queue should return it
    typedef struct {
        logic [STATUS_W-1:0] status;
        t_entry              head;
        logic [OCC_W-1:0]    occ;
    } t_reply;

    // sorted copy of the queue and the replies it predicts
    class task_queue_model;
        t_entry      held[QDEPTH];
        int unsigned held_cnt;
        t_reply      replies_due[$];
        int          mismatches;

        function new();
            held_cnt   = 0;
            mismatches = 0;
        endfunction

        // held entry a keeps its place ahead of newcomer b
        function bit keeps_place(t_entry a, t_entry b);
            if (a.prio != b.prio) begin
                return a.prio < b.prio;
            end
            return a.due <= b.due;
        endfunction

        // apply one accepted input word and queue the reply it causes
        function void take_request(logic func, t_entry e);
            t_reply      r;
            int unsigned pos;
            r.status = ST_DONE;
            r.head   = '0;
            if (func == FUNC_PUSH) begin
                if (held_cnt >= QDEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    pos = 0;
                    while (pos < held_cnt && keeps_place(held[pos], e)) pos++;
                    for (int i = held_cnt; i > pos; i--) held[i] = held[i-1];
                    held[pos] = e;
                    held_cnt++;
                end
            end else begin
                if (held_cnt == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    r.head = held[0];
                    for (int i = 1; i < held_cnt; i++) held[i-1] = held[i];
                    held_cnt--;
                end
            end
            r.occ = held_cnt[OCC_W-1:0];
            replies_due.push_back(r);
        endfunction

        function void flag_field(string what, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
                mismatches++;
            end
        endfunction

        // compare one accepted result word with the oldest prediction
        function void match_reply(logic [OUT_DATA_W-1:0] word, logic [STATUS_W-1:0] st);
            t_reply r;
            t_entry got;
            if (replies_due.size() == 0) begin
                $display("%0t: unexpected result word, expected none, got %0h status %0h",
                         $time, word, st);
                mismatches++;
                return;
            end
            r   = replies_due.pop_front();
            got = t_entry'(word[PRIO_W+DUE_W+TAG_W-1:0]);
            flag_field("status", 32'(r.status), 32'(st));
            flag_field("out_prio", 32'(r.head.prio), 32'(got.prio));
            flag_field("out_due", r.head.due, got.due);
            flag_field("out_tag", 32'(r.head.tag), 32'(got.tag));
            flag_field("occupancy", 32'(r.occ), 32'(word[54:50]));
        endfunction

        function int pending();
            return replies_due.size();
        endfunction
    endclass

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
    logic                  s_axis_tuser  = FUNC_PUSH;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic [STATUS_W-1:0]   m_axis_tuser;

    task_queue_model sb;
    int tx_idle_pct  = 0;
    int rx_stall_pct = 0;
    int rx_hold_req  = 0;
    int rx_hold_left = 0;
    int quiet_cycles = 0;
    int tx_idle_tab[4]  = '{0, 76, 0, 22};
    int rx_stall_tab[4] = '{0, 0, 76, 22};

    priority_deadline_queue #(
        .DEPTH(QDEPTH)
    ) u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // 12 ns clock
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // receiver: random stalls, or a long hold-off when one is requested
    always @(negedge i_clk) begin
        if (rx_hold_req != 0) begin
            rx_hold_left = rx_hold_req;
            rx_hold_req  = 0;
        end
        if (rx_hold_left != 0) begin
            m_axis_tready = 1'b0;
            rx_hold_left--;
        end else begin
            m_axis_tready = ($urandom_range(0, 99) >= rx_stall_pct);
        end
    end

    // result word monitor
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            sb.match_reply(m_axis_tdata, m_axis_tuser);
        end
    end

    // watchdog on cycles with no word moving on either side
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= QUIET_MAX) begin
                $display("FAIL");
                $finish;
            end
        end
    end

    // offer one word, with random idle cycles ahead of it, until taken
    task automatic send_word(logic func, t_entry e);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tuser  = func;
        s_axis_tdata  = {{(IN_DATA_W - $bits(t_entry)){1'b0}}, e};
        do @(posedge i_clk); while (!s_axis_tready);
        sb.take_request(func, e);
    endtask

    task automatic push_word(logic [PRIO_W-1:0] p, logic [DUE_W-1:0] d, logic [TAG_W-1:0] t);
        t_entry e;
        e.prio = p;
        e.due  = d;
        e.tag  = t;
        send_word(FUNC_PUSH, e);
    endtask

    // drop valid and wait for every outstanding result word
    task automatic drain_results();
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    // random key: clustered near both ends of the due range for ties
    function automatic t_entry random_entry();
        t_entry e;
        e.prio = PRIO_W'($urandom_range(0, 3));
        case ($urandom_range(0, 3))
            0: e.due = DUE_W'($urandom_range(0, 7));
            1: e.due = 32'hFFFF_FFF8 + DUE_W'($urandom_range(0, 7));
            default: e.due = $urandom;
        endcase
        e.tag = TAG_W'($urandom_range(0, 65535));
        return e;
    endfunction

    initial begin
        int push_bias;
        sb = new();
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: pop on empty, key extremes, equal keys, fill up, push when full
        send_word(FUNC_POP, '0);
        push_word(2'd3, 32'hFFFF_FFFF, 16'hFFFF);
        push_word(2'd0, 32'h0, 16'h0);
        push_word(2'd1, 32'd100, 16'd1);
        push_word(2'd1, 32'd100, 16'd2);
        push_word(2'd1, 32'd100, 16'd3);
        push_word(2'd1, 32'd99, 16'd4);
        push_word(2'd2, 32'd100, 16'd5);
        push_word(2'd0, 32'hFFFF_FFFF, 16'd6);
        push_word(2'd3, 32'h0, 16'd7);
        push_word(2'd0, 32'h0, 16'd8);
        push_word(2'd2, 32'h5555_5555, 16'hAAAA);
        push_word(2'd1, 32'hAAAA_AAAA, 16'h5555);
        push_word(2'd3, 32'hFFFF_FFFF, 16'd9);
        push_word(2'd2, 32'd100, 16'd10);
        push_word(2'd0, 32'd1, 16'd11);
        push_word(2'd1, 32'd100, 16'd12);
        push_word(2'd0, 32'h0, 16'd13);
        repeat (4) send_word(FUNC_POP, random_entry());
        drain_results();

        // random phases with different idling on each side
        for (int ph = 0; ph < 4; ph++) begin
            tx_idle_pct  = tx_idle_tab[ph];
            rx_stall_pct = rx_stall_tab[ph];
            push_bias    = 50;
            for (int n = 0; n < PHASE_LEN; n++) begin
                // swing between filling and emptying the queue
                if (n % CHUNK_LEN == 0) begin
                    case ($urandom_range(0, 2))
                        0: push_bias = 85;
                        1: push_bias = 50;
                        default: push_bias = 15;
                    endcase
                end
                // long receiver hold-off while pushes keep coming
                if (ph == 0 && n == 200) begin
                    rx_hold_req = HOLD_LEN;
                    push_bias   = 90;
                end
                if ($urandom_range(0, 99) < push_bias) begin
                    send_word(FUNC_PUSH, random_entry());
                end else begin
                    send_word(FUNC_POP, random_entry());
                end
            end
            drain_results();
        end

        repeat (10) @(posedge i_clk);
        if (sb.mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
